// ===== hdl/tbcd_pkg.sv =====
`default_nettype none
package tbcd_pkg;

    // Hold length counter width
    localparam int HOLD_BITS = 8;
    localparam int CMP_W     = (HOLD_BITS > 8) ? HOLD_BITS : 8;
    localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED_REG = 2'd2;

    localparam logic [7:0]  RST_LONG_HOLD   = 8'd5;
    localparam logic [15:0] RST_CLICK_WIN   = 16'd100;
    localparam logic [7:0]  RST_WATCHED_REG = 8'h12;

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Port patterns
    localparam logic [7:0] NIBBLE_MASK = 8'hF0;
    localparam logic [7:0] PAT_A_PRESS = 8'h40;
    localparam logic [7:0] PAT_B_PRESS = 8'h80;
    localparam logic [7:0] PAT_RELEASE = 8'hC0;

    localparam logic [1:0] CLICKS_MANY = 2'd3;

    // Results of one item
    localparam int MAX_EV   = 4;
    localparam int EV_CNT_W = 3;

    // Event queue
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = 3;
    localparam int Q_CNT_W = 4;

    typedef enum logic [1:0] {
        EV_A_CLICK = 2'd0,
        EV_B_CLICK = 2'd1,
        EV_A_LONG  = 2'd2,
        EV_B_LONG  = 2'd3
    } t_event;

    typedef struct packed {
        logic [EV_CNT_W-1:0]     count;
        logic [MAX_EV-1:0][1:0]  codes;
    } t_batch;

endpackage
`default_nettype wire

// ===== hdl/tbcd_classifier.sv =====
`default_nettype none
module tbcd_classifier (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tbcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tbcd_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_valid,
    input  wire logic                               i_kind,
    input  wire logic [7:0]                         i_reg_addr,
    input  wire logic [7:0]                         i_port_value,
    output tbcd_pkg::t_batch                        o_batch
);
    import tbcd_pkg::*;

    logic [7:0]           r_long_hold;
    logic [15:0]          r_click_win;
    logic [7:0]           r_watched;

    logic [7:0]           r_a_prev, n_a_prev;
    logic [7:0]           r_b_prev, n_b_prev;
    logic                 r_a_held, n_a_held;
    logic                 r_b_held, n_b_held;
    logic [HOLD_BITS-1:0] r_a_len, n_a_len;
    logic [HOLD_BITS-1:0] r_b_len, n_b_len;
    logic [1:0]           r_a_clicks, n_a_clicks;
    logic [1:0]           r_b_clicks, n_b_clicks;
    logic [15:0]          r_window, n_window;

    logic [7:0]           hi;
    logic                 watch, is_sample, is_tick, expire;
    logic                 a_press, a_rel, a_long;
    logic                 b_press, b_rel, b_long;
    logic [15:0]          win_arm;
    logic [CMP_W-1:0]     thr;
    t_batch               batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_hold <= RST_LONG_HOLD;
            r_click_win <= RST_CLICK_WIN;
            r_watched   <= RST_WATCHED_REG;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_HOLD:   r_long_hold <= i_cfg_data[7:0];
                CFG_CLICK_WIN:   r_click_win <= i_cfg_data[15:0];
                CFG_WATCHED_REG: r_watched   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        hi        = i_port_value & NIBBLE_MASK;
        watch     = (i_reg_addr == r_watched);
        is_sample = i_valid && (i_kind == KIND_SAMPLE);
        is_tick   = i_valid && (i_kind == KIND_TICK);
        thr       = CMP_W'(r_long_hold);
        win_arm   = (r_click_win == 16'd0) ? 16'd1 : r_click_win;

        a_press = is_sample && watch && (hi == PAT_A_PRESS);
        a_rel   = is_sample && watch && !a_press && (r_a_prev == PAT_A_PRESS)
                  && (hi == PAT_RELEASE);
        a_long  = a_rel && (CMP_W'(r_a_len) >= thr);

        b_press = is_sample && watch && (i_port_value == PAT_B_PRESS);
        b_rel   = is_sample && watch && !b_press && (r_b_prev == PAT_B_PRESS)
                  && (i_port_value == PAT_RELEASE);
        b_long  = b_rel && (CMP_W'(r_b_len) >= thr);

        expire  = is_tick && (r_window == 16'd1);

        n_a_prev   = r_a_prev;
        n_b_prev   = r_b_prev;
        n_a_held   = r_a_held;
        n_b_held   = r_b_held;
        n_a_len    = r_a_len;
        n_b_len    = r_b_len;
        n_a_clicks = r_a_clicks;
        n_b_clicks = r_b_clicks;
        n_window   = r_window;

        if (is_sample) begin
            n_a_prev = hi;
            n_b_prev = i_port_value;
        end

        if (a_press) begin
            if (!r_a_held) begin
                n_a_held = 1'b1;
                n_a_len  = HOLD_BITS'(1);
            end else if (r_a_len != HOLD_MAX) begin
                n_a_len = r_a_len + HOLD_BITS'(1);
            end
        end else if (a_rel) begin
            if (!a_long && (r_a_clicks != CLICKS_MANY)) begin
                n_a_clicks = r_a_clicks + 2'd1;
            end
            n_a_held = 1'b0;
            n_a_len  = '0;
        end

        if (b_press) begin
            if (!r_b_held) begin
                n_b_held = 1'b1;
                n_b_len  = HOLD_BITS'(1);
            end else if (r_b_len != HOLD_MAX) begin
                n_b_len = r_b_len + HOLD_BITS'(1);
            end
        end else if (b_rel) begin
            if (!b_long && (r_b_clicks != CLICKS_MANY)) begin
                n_b_clicks = r_b_clicks + 2'd1;
            end
            n_b_held = 1'b0;
            n_b_len  = '0;
        end

        if (a_rel || b_rel) begin
            n_window = win_arm;
        end else if (is_tick && (r_window != 16'd0)) begin
            n_window = r_window - 16'd1;
        end

        if (expire) begin
            n_a_clicks = '0;
            n_b_clicks = '0;
        end

        // Collect events in report order
        batch = '0;
        if (a_long) begin
            batch.codes[batch.count[1:0]] = EV_A_LONG;
            batch.count = batch.count + EV_CNT_W'(1);
        end
        if (b_long) begin
            batch.codes[batch.count[1:0]] = EV_B_LONG;
            batch.count = batch.count + EV_CNT_W'(1);
        end
        if (expire && (r_a_clicks == 2'd1 || r_a_clicks == 2'd2)) begin
            batch.codes[batch.count[1:0]] = EV_A_CLICK;
            batch.count = batch.count + EV_CNT_W'(1);
        end
        if (expire && (r_a_clicks == 2'd2)) begin
            batch.codes[batch.count[1:0]] = EV_A_CLICK;
            batch.count = batch.count + EV_CNT_W'(1);
        end
        if (expire && (r_b_clicks == 2'd1 || r_b_clicks == 2'd2)) begin
            batch.codes[batch.count[1:0]] = EV_B_CLICK;
            batch.count = batch.count + EV_CNT_W'(1);
        end
        if (expire && (r_b_clicks == 2'd2)) begin
            batch.codes[batch.count[1:0]] = EV_B_CLICK;
            batch.count = batch.count + EV_CNT_W'(1);
        end
    end

    assign o_batch = batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_prev   <= PAT_RELEASE;
            r_b_prev   <= PAT_RELEASE;
            r_a_held   <= 1'b0;
            r_b_held   <= 1'b0;
            r_a_len    <= '0;
            r_b_len    <= '0;
            r_a_clicks <= '0;
            r_b_clicks <= '0;
            r_window   <= '0;
        end else begin
            r_a_prev   <= n_a_prev;
            r_b_prev   <= n_b_prev;
            r_a_held   <= n_a_held;
            r_b_held   <= n_b_held;
            r_a_len    <= n_a_len;
            r_b_len    <= n_b_len;
            r_a_clicks <= n_a_clicks;
            r_b_clicks <= n_b_clicks;
            r_window   <= n_window;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/two_button_click_long_press_detector.sv =====
// Flow: a transaction is registered, classified in the next cycle and its events
// enter the output queue, which offers the first event once the write is registered.
// Throughput: one transaction per cycle while the queued events, plus four for an
// item still in the input register, number four or fewer; events drain one per cycle
// while i_out_stall is low. Reset: synchronous, active low; restores the control and
// configuration registers to their defaults and empties the queue.
`default_nettype none
module two_button_click_long_press_detector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tbcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tbcd_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire logic                               i_kind,
    input  wire logic [7:0]                         i_reg_addr,
    input  wire logic [7:0]                         i_port_value,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output      logic [1:0]                         o_event_code,
    output      logic                               o_last
);
    import tbcd_pkg::*;

    logic                 r_in_v;
    logic                 r_kind;
    logic [7:0]           r_reg_addr;
    logic [7:0]           r_port_value;

    logic [1:0]           r_q_code [Q_DEPTH];
    logic                 r_q_last [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    logic                 in_acc, out_acc;
    logic [Q_CNT_W:0]     reserved;
    t_batch               batch;

    // Reserve room for the worst case of the item already in the input register
    assign reserved   = {1'b0, r_count} + (r_in_v ? (Q_CNT_W+1)'(MAX_EV) : '0);
    assign o_in_stall = reserved > (Q_CNT_W+1)'(Q_DEPTH - MAX_EV);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid  = (r_count != '0);
    assign o_event_code = r_q_code[r_rd_ptr];
    assign o_last       = r_q_last[r_rd_ptr];
    assign out_acc      = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind       <= i_kind;
            r_reg_addr   <= i_reg_addr;
            r_port_value <= i_port_value;
        end
    end

    tbcd_classifier u_classifier (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (r_in_v),
        .i_kind       (r_kind),
        .i_reg_addr   (r_reg_addr),
        .i_port_value (r_port_value),
        .o_batch      (batch)
    );

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(batch.count);
        n_rd_ptr = r_rd_ptr + (out_acc ? Q_PTR_W'(1) : '0);
        n_count  = r_count + Q_CNT_W'(batch.count) - (out_acc ? Q_CNT_W'(1) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Write the whole batch of one item at once; flag its final event
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_EV; k++) begin
            if (EV_CNT_W'(k) < batch.count) begin
                r_q_code[r_wr_ptr + Q_PTR_W'(k)] <= batch.codes[k];
                r_q_last[r_wr_ptr + Q_PTR_W'(k)] <=
                    (EV_CNT_W'(k) == batch.count - EV_CNT_W'(1));
            end
        end
    end

`ifndef SYNTH
    a_room_for_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_v |-> (r_count <= Q_CNT_W'(Q_DEPTH - MAX_EV)))
        else $error("queue lacks room for a classified item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_count <= Q_CNT_W'(Q_DEPTH)))
        else $error("event queue count out of range");

    a_batch_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (r_count > Q_CNT_W'(1)))
        else $error("non-final event without its follower queued");
`endif

endmodule
`default_nettype wire

// ===== tb/button_event_checker.sv =====
`timescale 1ns / 1ps
module button_event_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tbcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tbcd_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire logic                           i_kind,
    input  wire logic [7:0]                     i_reg_addr,
    input  wire logic [7:0]                     i_port_value,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire logic [1:0]                     i_event_code,
    input  wire logic                           i_last,
    output int                                  o_mismatches,
    output int                                  o_pending,
    output int                                  o_items,
    output int                                  o_events
);
    import tbcd_pkg::*;

    typedef struct packed {
        t_event code;
        logic   last;
    } t_expected_event;

    t_expected_event expected_events[$];
    t_expected_event want;
    t_event          batch[$];

    // configuration as seen by the block
    logic [7:0]  hold_thr;
    logic [15:0] win_len;
    logic [7:0]  watch_addr;

    // index 0 is button A, index 1 is button B
    logic                 btn_held[2];
    logic [HOLD_BITS-1:0] btn_len[2];
    logic [1:0]           btn_clicks[2];
    logic [7:0]           a_prev;
    logic [7:0]           b_prev;
    logic [15:0]          win_left;

    function automatic void press_button(int b);
        if (!btn_held[b]) begin
            btn_held[b] = 1'b1;
            btn_len[b]  = 1;
        end else if (btn_len[b] != HOLD_MAX) begin
            btn_len[b] = btn_len[b] + 1'b1;
        end
    endfunction

    function automatic void release_button(int b);
        if (btn_len[b] >= hold_thr) begin
            batch.push_back((b == 0) ? EV_A_LONG : EV_B_LONG);
        end else if (btn_clicks[b] != CLICKS_MANY) begin
            btn_clicks[b] = btn_clicks[b] + 1'b1;
        end
        // every release restarts the shared window
        win_left    = (win_len == 16'd0) ? 16'd1 : win_len;
        btn_held[b] = 1'b0;
        btn_len[b]  = '0;
    endfunction

    function automatic void report_clicks(int b);
        t_event code;
        code = (b == 0) ? EV_A_CLICK : EV_B_CLICK;
        if (btn_clicks[b] == 2'd1) begin
            batch.push_back(code);
        end else if (btn_clicks[b] == 2'd2) begin
            batch.push_back(code);
            batch.push_back(code);
        end
        btn_clicks[b] = 2'd0;
    endfunction

    function automatic void predict_events(logic kind, logic [7:0] addr, logic [7:0] value);
        logic            watched;
        logic [7:0]      nib;
        t_expected_event ev;
        batch.delete();
        if (kind == KIND_SAMPLE) begin
            watched = (addr == watch_addr);
            nib     = value & NIBBLE_MASK;
            if (watched && nib == PAT_A_PRESS) begin
                press_button(0);
            end else if (watched && a_prev == PAT_A_PRESS && nib == PAT_RELEASE) begin
                release_button(0);
            end
            a_prev = nib;
            if (watched && value == PAT_B_PRESS) begin
                press_button(1);
            end else if (watched && b_prev == PAT_B_PRESS && value == PAT_RELEASE) begin
                release_button(1);
            end
            b_prev = value;
        end else if (win_left != 16'd0) begin
            win_left = win_left - 1'b1;
            if (win_left == 16'd0) begin
                report_clicks(0);
                report_clicks(1);
            end
        end
        foreach (batch[i]) begin
            ev.code = batch[i];
            ev.last = (i == batch.size() - 1);
            expected_events.push_back(ev);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_thr   = RST_LONG_HOLD;
            win_len    = RST_CLICK_WIN;
            watch_addr = RST_WATCHED_REG;
            for (int b = 0; b < 2; b++) begin
                btn_held[b]   = 1'b0;
                btn_len[b]    = '0;
                btn_clicks[b] = 2'd0;
            end
            a_prev   = PAT_RELEASE;
            b_prev   = PAT_RELEASE;
            win_left = 16'd0;
            expected_events.delete();
        end else begin
            // compare first: no event can come from a transaction accepted this edge
            if (i_out_valid && !i_out_stall) begin
                o_events++;
                if (expected_events.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10)
                        $display("[%0t] unexpected event: code %0d last %0b",
                                 $realtime, i_event_code, i_last);
                end else begin
                    want = expected_events.pop_front();
                    if (i_event_code !== want.code || i_last !== want.last) begin
                        o_mismatches++;
                        if (o_mismatches <= 10)
                            $display({"[%0t] event mismatch: expected code %0d last %0b,",
                                      " got code %0d last %0b"},
                                     $realtime, want.code, want.last,
                                     i_event_code, i_last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LONG_HOLD:   hold_thr   = i_cfg_data[7:0];
                    CFG_CLICK_WIN:   win_len    = i_cfg_data;
                    CFG_WATCHED_REG: watch_addr = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                o_items++;
                predict_events(i_kind, i_reg_addr, i_port_value);
            end
        end
        o_pending = expected_events.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import tbcd_pkg::*;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [CFG_W-1:0]     cfg_data   = '0;
    logic                 in_valid   = 1'b0;
    logic                 kind       = KIND_SAMPLE;
    logic [7:0]           reg_addr   = 8'h00;
    logic [7:0]           port_value = 8'h00;
    logic                 out_stall  = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic [1:0]           event_code;
    logic                 last_flag;

    int mismatches;
    int pending;
    int items_seen;
    int events_seen;

    // current settings, used only to shape stimulus
    int cur_thr   = RST_LONG_HOLD;
    int cur_win   = RST_CLICK_WIN;
    int cur_watch = RST_WATCHED_REG;

    bit tx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;
    bit rx_holding  = 1'b0;

    two_button_click_long_press_detector dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_kind       (kind),
        .i_reg_addr   (reg_addr),
        .i_port_value (port_value),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_event_code (event_code),
        .o_last       (last_flag)
    );

    button_event_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_kind       (kind),
        .i_reg_addr   (reg_addr),
        .i_port_value (port_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_event_code (event_code),
        .i_last       (last_flag),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_items      (items_seen),
        .o_events     (events_seen)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] press_value(int b);
        return (b == 0) ? (PAT_A_PRESS | 8'($urandom_range(0, 15))) : PAT_B_PRESS;
    endfunction

    function automatic logic [7:0] release_value(int b);
        return (b == 0) ? (PAT_RELEASE | 8'($urandom_range(0, 15))) : PAT_RELEASE;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic k, logic [7:0] addr, logic [7:0] value);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        reg_addr   <= addr;
        port_value <= value;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic tick_burst(int n);
        repeat (n) send_item(KIND_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic press_release(int b, int n);
        repeat (n) send_item(KIND_SAMPLE, 8'(cur_watch), press_value(b));
        send_item(KIND_SAMPLE, 8'(cur_watch), release_value(b));
    endtask

    task automatic wait_drained(bit settle);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        // a transaction with no events may still be in the pipe
        if (settle) repeat (6) @(negedge clk);
    endtask

    task automatic set_config(int thr, int win, int watch);
        wait_drained(1'b1);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LONG_HOLD;
        cfg_data <= CFG_W'(thr);
        @(negedge clk);
        cfg_idx  <= CFG_CLICK_WIN;
        cfg_data <= CFG_W'(win);
        @(negedge clk);
        cfg_idx  <= CFG_WATCHED_REG;
        cfg_data <= CFG_W'(watch);
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_thr   = thr;
        cur_win   = win;
        cur_watch = watch;
    endtask

    task automatic random_traffic(int n_items);
        int sent;
        int r;
        int b;
        int len;
        int k;
        int cap;
        sent = 0;
        cap  = (cur_thr < 8) ? cur_thr : 8;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // well-formed press and release, sometimes mixing both buttons
                b   = $urandom_range(0, 2);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12)
                                                  : $urandom_range(1, cap + 1);
                for (k = 0; k < len; k++)
                    send_item(KIND_SAMPLE, 8'(cur_watch),
                              press_value((b == 2) ? $urandom_range(0, 1) : b));
                send_item(KIND_SAMPLE, 8'(cur_watch),
                          (b == 2) ? PAT_RELEASE : release_value(b));
                sent += len + 1;
                if ($urandom_range(0, 2) != 0) begin
                    k = $urandom_range(0, cur_win + 1);
                    tick_burst(k);
                    sent += k;
                end
            end else if (r < 85) begin
                k = $urandom_range(1, cur_win + 2);
                tick_burst(k);
                sent += k;
            end else begin
                send_item(KIND_SAMPLE,
                          ($urandom_range(0, 3) == 0) ? 8'(cur_watch) : 8'($urandom),
                          8'($urandom));
                sent += 1;
            end
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        int n;
        int r;
        @(negedge clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                out_stall  <= 1'b1;
                n = 80;
            end else begin
                rx_holding = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    out_stall <= 1'b0;
                    n = $urandom_range(20, 60);
                end else if (r < 60) begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 8);
                end else if (r < 92) begin
                    out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    n = $urandom_range(10, 30);
                end
            end
            repeat (n) @(negedge clk);
        end
    end

    initial begin
        #20_000_000;
        $display("** two_button_click_long_press_detector: FAILED **");
        $finish;
    end

    initial begin
        int bound;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: idle tick, other register, stray releases, holds and clicks
        send_item(KIND_TICK, 8'hFF, 8'hFF);
        send_item(KIND_SAMPLE, 8'(cur_watch + 1), PAT_A_PRESS);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_RELEASE);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_RELEASE);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_A_PRESS);
        send_item(KIND_SAMPLE, 8'(cur_watch), 8'h55);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_A_PRESS | 8'h01);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_A_PRESS | 8'h0E);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_A_PRESS | 8'h0F);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_A_PRESS);
        send_item(KIND_SAMPLE, 8'(cur_watch), PAT_RELEASE | 8'h0F);
        press_release(1, 5);
        press_release(1, 1);
        press_release(1, 1);
        tick_burst(4);

        // zero threshold and zero window
        set_config(0, 0, 8'h00);
        send_item(KIND_SAMPLE, 8'h00, 8'h00);
        press_release(0, 1);
        press_release(1, 1);
        tick_burst(2);
        set_config(2, 0, 8'h00);
        repeat (3) press_release(0, 1);
        repeat (2) press_release(1, 1);
        tick_burst(1);

        // top of the ranges
        set_config(255, 16'hFFFF, 8'hFF);
        send_item(KIND_SAMPLE, 8'hFF, 8'hFF);
        press_release(0, 3);
        press_release(1, 2);
        tick_burst(3);

        set_config($urandom_range(2, 6), $urandom_range(1, 5), RST_WATCHED_REG);
        random_traffic(15);

        // hold the output back while offering steadily, so the queue fills
        set_config(1, 1, 8'h00);
        rx_hold_req = 1'b1;
        wait (rx_holding);
        tx_steady = 1'b1;
        repeat (12) press_release($urandom_range(0, 1), 1);
        tx_steady = 1'b0;
        random_traffic(10);

        set_config($urandom_range(1, 8), $urandom_range(2, 8), $urandom_range(0, 255));
        random_traffic(10);
        wait_drained(1'b0);
        random_traffic(8);

        set_config($urandom_range(3, 8), $urandom_range(1, 8), 8'hFF);
        random_traffic(8);

        in_valid <= 1'b0;
        bound = 0;
        while (pending != 0 && bound < 20000) begin
            @(negedge clk);
            bound++;
        end
        repeat (10) @(negedge clk);

        $display("Covered %0d input transactions and %0d events over 8 register settings,",
                 items_seen, events_seen);
        $display("including zero and maximum settings, click overflow and a full event queue.");
        if (mismatches == 0 && pending == 0) begin
            $display("** two_button_click_long_press_detector: PASSED **");
        end else begin
            $display("%0d mismatches, %0d events never arrived", mismatches, pending);
            $display("** two_button_click_long_press_detector: FAILED **");
        end
        $finish;
    end

endmodule
